/* design/brl_pkg.sv */
// brl_pkg: shared types for the Bresenham line rasterizer.
// No dependencies; imported by bresenham_line_rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

endpackage

/* design/brl_setup.sv */
// brl_setup: line set-up from two endpoints (deltas, directions, major axis).
// Combinational; depends on nothing else.
`timescale 1ns / 1ps

module brl_setup #(
   parameter int COORD_BITS = 11
) (
   input  logic [COORD_BITS-1:0]        start_x,
   input  logic [COORD_BITS-1:0]        start_y,
   input  logic [COORD_BITS-1:0]        end_x,
   input  logic [COORD_BITS-1:0]        end_y,
   output logic                         step_x_negative,
   output logic                         step_y_negative,
   output logic                         x_is_major,
   output logic [COORD_BITS-1:0]        abs_delta_major,
   output logic [COORD_BITS-1:0]        abs_delta_minor,
   output logic signed [COORD_BITS+2:0] decision_term
);

   localparam int DW = COORD_BITS + 3;

   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;

   always_comb begin
      step_x_negative = end_x < start_x;
      step_y_negative = end_y < start_y;
      adx = step_x_negative ? start_x - end_x : end_x - start_x;
      ady = step_y_negative ? start_y - end_y : end_y - start_y;
      x_is_major = adx > ady;
      abs_delta_major = x_is_major ? adx : ady;
      abs_delta_minor = x_is_major ? ady : adx;
      decision_term = $signed(DW'({abs_delta_minor, 1'b0})) - $signed(DW'(abs_delta_major));
   end

endmodule

/* design/brl_step.sv */
// brl_step: one Bresenham step along the major axis.
// Combinational; depends on nothing else.
`timescale 1ns / 1ps

module brl_step #(
   parameter int COORD_BITS = 11
) (
   input  logic [COORD_BITS-1:0]        cur_x,
   input  logic [COORD_BITS-1:0]        cur_y,
   input  logic                         step_x_negative,
   input  logic                         step_y_negative,
   input  logic                         x_is_major,
   input  logic [COORD_BITS-1:0]        abs_delta_major,
   input  logic [COORD_BITS-1:0]        abs_delta_minor,
   input  logic signed [COORD_BITS+2:0] decision_term,
   input  logic [COORD_BITS-1:0]        steps_left,
   output logic [COORD_BITS-1:0]        next_x,
   output logic [COORD_BITS-1:0]        next_y,
   output logic signed [COORD_BITS+2:0] next_decision,
   output logic [COORD_BITS-1:0]        next_steps_left,
   output logic                         last
);

   localparam int DW = COORD_BITS + 3;

   logic                 minor_move;
   logic                 x_adv;
   logic                 y_adv;
   logic signed [DW-1:0] twice_minor;
   logic signed [DW-1:0] twice_major;

   always_comb begin
      minor_move  = !decision_term[DW-1];
      twice_minor = $signed(DW'({abs_delta_minor, 1'b0}));
      twice_major = $signed(DW'({abs_delta_major, 1'b0}));
      next_decision = minor_move ? decision_term + twice_minor - twice_major
                                 : decision_term + twice_minor;
      x_adv = x_is_major || minor_move;
      y_adv = !x_is_major || minor_move;
      next_x = cur_x;
      if (x_adv) begin
         next_x = step_x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      next_y = cur_y;
      if (y_adv) begin
         next_y = step_y_negative ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      next_steps_left = steps_left - 1'b1;
      last = next_steps_left == '0;
   end

endmodule

/* design/bresenham_line_rasterizer.sv */
// bresenham_line_rasterizer: top level, input register, line state and result register.
// Depends on brl_pkg, brl_setup and brl_step.
//
//   channel | direction | tdata (low bit up)                   | tuser       | tlast
//   req_    | in        | start_x, start_y, end_x, end_y       | action      | -
//   rsp_    | out       | pixel_x, pixel_y                     | pixel_valid | last_pixel
//
// One beat in, one beat out; a new beat is taken every cycle while results drain.
// A beat passes through the input register, then set-up or step logic into the result register.
// The line state updates when a beat leaves the input register, so each step sees the last.
// Reset (synchronous, active high) empties both registers and leaves the line idle.
// A stalled result holds the input register, which then holds req_tready low.
`timescale 1ns / 1ps

module bresenham_line_rasterizer
   import brl_pkg::*;
#(
   parameter int COORD_BITS = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]    req_tdata,  // start_x, start_y, end_x, end_y
   input  logic                                 req_tuser,  // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0]    rsp_tdata,  // pixel_x, pixel_y
   output logic                                 rsp_tuser,  // pixel_valid
   output logic                                 rsp_tlast   // last_pixel
);

   localparam int N  = COORD_BITS;
   localparam int DW = COORD_BITS + 3;
   localparam int RSP_W = ((2*COORD_BITS+7)/8)*8;

   // input register
   logic         in_valid_ff, in_valid_in;
   action_type   in_action_ff;
   logic [N-1:0] in_sx_ff, in_sy_ff, in_ex_ff, in_ey_ff;

   // line state
   logic                 line_active_ff, line_active_in;
   logic [N-1:0]         cur_x_ff, cur_x_in;
   logic [N-1:0]         cur_y_ff, cur_y_in;
   logic                 step_x_neg_ff, step_x_neg_in;
   logic                 step_y_neg_ff, step_y_neg_in;
   logic                 x_major_ff, x_major_in;
   logic [N-1:0]         d_major_ff, d_major_in;
   logic [N-1:0]         d_minor_ff, d_minor_in;
   logic signed [DW-1:0] decision_ff, decision_in;
   logic [N-1:0]         steps_left_ff, steps_left_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [N-1:0] rsp_x_ff, rsp_x_in;
   logic [N-1:0] rsp_y_ff, rsp_y_in;
   logic         rsp_pv_ff, rsp_pv_in;
   logic         rsp_last_ff, rsp_last_in;

   logic advance;
   logic fire;

   // set-up and step results
   logic                 su_xneg, su_yneg, su_xmaj;
   logic [N-1:0]         su_dmaj, su_dmin;
   logic signed [DW-1:0] su_dec;
   logic [N-1:0]         st_x, st_y, st_steps;
   logic signed [DW-1:0] st_dec;
   logic                 st_last;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   brl_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .start_x         (in_sx_ff),
      .start_y         (in_sy_ff),
      .end_x           (in_ex_ff),
      .end_y           (in_ey_ff),
      .step_x_negative (su_xneg),
      .step_y_negative (su_yneg),
      .x_is_major      (su_xmaj),
      .abs_delta_major (su_dmaj),
      .abs_delta_minor (su_dmin),
      .decision_term   (su_dec)
   );

   brl_step #(.COORD_BITS(COORD_BITS)) u_step (
      .cur_x           (cur_x_ff),
      .cur_y           (cur_y_ff),
      .step_x_negative (step_x_neg_ff),
      .step_y_negative (step_y_neg_ff),
      .x_is_major      (x_major_ff),
      .abs_delta_major (d_major_ff),
      .abs_delta_minor (d_minor_ff),
      .decision_term   (decision_ff),
      .steps_left      (steps_left_ff),
      .next_x          (st_x),
      .next_y          (st_y),
      .next_decision   (st_dec),
      .next_steps_left (st_steps),
      .last            (st_last)
   );

   always_comb begin
      in_valid_in    = req_tready ? req_tvalid : in_valid_ff;
      line_active_in = line_active_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      step_x_neg_in  = step_x_neg_ff;
      step_y_neg_in  = step_y_neg_ff;
      x_major_in     = x_major_ff;
      d_major_in     = d_major_ff;
      d_minor_in     = d_minor_ff;
      decision_in    = decision_ff;
      steps_left_in  = steps_left_ff;
      rsp_valid_in   = advance ? in_valid_ff : rsp_valid_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_pv_in      = rsp_pv_ff;
      rsp_last_in    = rsp_last_ff;
      if (fire) begin
         unique case (in_action_ff)
            ACT_LOAD: begin
               cur_x_in       = in_sx_ff;
               cur_y_in       = in_sy_ff;
               step_x_neg_in  = su_xneg;
               step_y_neg_in  = su_yneg;
               x_major_in     = su_xmaj;
               d_major_in     = su_dmaj;
               d_minor_in     = su_dmin;
               decision_in    = su_dec;
               steps_left_in  = su_dmaj;
               line_active_in = su_dmaj != '0;
               rsp_x_in       = in_sx_ff;
               rsp_y_in       = in_sy_ff;
               rsp_pv_in      = 1'b1;
               rsp_last_in    = su_dmaj == '0;
            end
            ACT_STEP: begin
               if (line_active_ff) begin
                  cur_x_in       = st_x;
                  cur_y_in       = st_y;
                  decision_in    = st_dec;
                  steps_left_in  = st_steps;
                  line_active_in = !st_last;
                  rsp_x_in       = st_x;
                  rsp_y_in       = st_y;
                  rsp_pv_in      = 1'b1;
                  rsp_last_in    = st_last;
               end else begin
                  rsp_x_in    = '0;
                  rsp_y_in    = '0;
                  rsp_pv_in   = 1'b0;
                  rsp_last_in = 1'b0;
               end
            end
            default: begin
               rsp_pv_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         line_active_ff <= 1'b0;
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         step_x_neg_ff  <= 1'b0;
         step_y_neg_ff  <= 1'b0;
         x_major_ff     <= 1'b0;
         d_major_ff     <= '0;
         d_minor_ff     <= '0;
         decision_ff    <= '0;
         steps_left_ff  <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         line_active_ff <= line_active_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         step_x_neg_ff  <= step_x_neg_in;
         step_y_neg_ff  <= step_y_neg_in;
         x_major_ff     <= x_major_in;
         d_major_ff     <= d_major_in;
         d_minor_ff     <= d_minor_in;
         decision_ff    <= decision_in;
         steps_left_ff  <= steps_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_action_ff <= action_type'(req_tuser);
         in_sx_ff     <= req_tdata[N-1:0];
         in_sy_ff     <= req_tdata[2*N-1:N];
         in_ex_ff     <= req_tdata[3*N-1:2*N];
         in_ey_ff     <= req_tdata[4*N-1:3*N];
      end
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_pv_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_idle_beat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pv_ff |-> !rsp_last_ff && rsp_x_ff == '0 && rsp_y_ff == '0)
      else $error("idle step beat carries pixel data");

   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> steps_left_ff != '0)
      else $error("line active with no steps left");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      fire |=> !rsp_pv_ff || (rsp_last_ff == !line_active_ff))
      else $error("last pixel flag disagrees with line state");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input register empty but not ready");

endmodule
